// ----- src/dfr_pkg.sv -----
`timescale 1ns / 1ps
package dfr_pkg;

  // sizing
  localparam int CHANNELS = 512;
  localparam int RX_DEPTH = 514;

  localparam int RX_CNT_W = $clog2(RX_DEPTH + 1);
  localparam int RX_IDX_W = $clog2(RX_DEPTH);
  localparam int CH_CNT_W = $clog2(CHANNELS + 1);
  localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int ADDR_W   = ((RX_CNT_W > CH_CNT_W) ? RX_CNT_W : CH_CNT_W) + 1;

  // field widths
  localparam int KIND_W = 3;
  localparam int BYTE_W = 8;
  localparam int CHAN_W = 10;
  localparam int TMO_W  = 16;
  localparam int PKT_W  = 32;

  // event kinds
  localparam logic [KIND_W-1:0] KIND_BYTE  = 3'd0;
  localparam logic [KIND_W-1:0] KIND_BREAK = 3'd1;
  localparam logic [KIND_W-1:0] KIND_FLUSH = 3'd2;
  localparam logic [KIND_W-1:0] KIND_TICK  = 3'd3;
  localparam logic [KIND_W-1:0] KIND_READ  = 3'd4;

  // frame layout and defaults
  localparam int HDR_BYTES = 2;
  localparam int MIN_FRAME = 3;
  localparam logic [TMO_W-1:0] TIMEOUT_RST = 16'd1000;

  // controller to datapath
  typedef struct packed {
    logic latch_item;
    logic do_byte;
    logic do_clear;
    logic do_tick;
    logic do_read;
    logic copy_start;
    logic copy_rd;
    logic copy_wr;
    logic commit;
    logic load_out;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic              rx_ge3;
    logic              copy_last;
    logic              out_free;
  } status_t;

endpackage

// ----- src/dfr_if.sv -----
`timescale 1ns / 1ps
interface dfr_in_if;
  logic                        valid;
  logic                        ready;
  logic [dfr_pkg::KIND_W-1:0]  kind;
  logic [dfr_pkg::BYTE_W-1:0]  data_byte;
  logic [dfr_pkg::CHAN_W-1:0]  channel;

  modport source (output valid, output kind, output data_byte, output channel, input ready);
  modport sink   (input valid, input kind, input data_byte, input channel, output ready);
endinterface

interface dfr_out_if;
  logic                        valid;
  logic                        ready;
  logic [dfr_pkg::BYTE_W-1:0]  channel_value;
  logic [dfr_pkg::PKT_W-1:0]   packet_count;
  logic                        data_recent;
  logic                        frame_accepted;

  modport source (output valid, output channel_value, output packet_count,
                  output data_recent, output frame_accepted, input ready);
  modport sink   (input valid, input channel_value, input packet_count,
                  input data_recent, input frame_accepted, output ready);
endinterface

interface dfr_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [dfr_pkg::TMO_W-1:0]   data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- src/dfr_datapath.sv -----
`timescale 1ns / 1ps
module dfr_datapath (
  input  logic                        clk,
  input  logic                        rst_n,
  input  dfr_pkg::cmd_t               cmd,
  output dfr_pkg::status_t            st,
  input  logic [dfr_pkg::KIND_W-1:0]  in_kind,
  input  logic [dfr_pkg::BYTE_W-1:0]  in_data_byte,
  input  logic [dfr_pkg::CHAN_W-1:0]  in_channel,
  input  logic                        cfg_we,
  input  logic [dfr_pkg::TMO_W-1:0]   cfg_data,
  input  logic                        out_ready,
  output logic                        out_valid,
  output logic [dfr_pkg::BYTE_W-1:0]  out_channel_value,
  output logic [dfr_pkg::PKT_W-1:0]   out_packet_count,
  output logic                        out_data_recent,
  output logic                        out_frame_accepted
);
  import dfr_pkg::*;

  // held item
  logic [KIND_W-1:0]   kind_r;
  logic [BYTE_W-1:0]   byte_r;
  logic [CHAN_W-1:0]   chan_r;

  // block state
  logic [RX_CNT_W-1:0] rx_count_r;
  logic [PKT_W-1:0]    pkt_r;
  logic [TMO_W-1:0]    ms_r;
  logic                seen_r;
  logic [CH_CNT_W-1:0] fill_r;
  logic [TMO_W-1:0]    timeout_r;
  logic                acc_r;
  logic                rd_ok_r;

  // copy loop
  logic [CH_IDX_W-1:0] copy_idx_r;
  logic [CH_CNT_W-1:0] copy_len_r;

  // memories
  logic [BYTE_W-1:0]   rx_mem [RX_DEPTH];
  logic [BYTE_W-1:0]   ch_mem [CHANNELS];
  logic [BYTE_W-1:0]   rx_rdata_r;
  logic [BYTE_W-1:0]   ch_rdata_r;

  // result register
  logic                out_valid_r;
  logic [BYTE_W-1:0]   out_value_r;
  logic [PKT_W-1:0]    out_pkt_r;
  logic                out_recent_r;
  logic                out_acc_r;

  logic [ADDR_W-1:0]   len_raw;
  logic [ADDR_W-1:0]   len_clip;
  logic [RX_IDX_W-1:0] rx_rd_addr;
  logic [CHAN_W-1:0]   chan_m1;
  logic                rd_ok;
  logic                recent;

  // frame length after the two header bytes, clipped to the channel count
  assign len_raw  = ADDR_W'(rx_count_r) - ADDR_W'(HDR_BYTES);
  assign len_clip = (len_raw > ADDR_W'(CHANNELS)) ? ADDR_W'(CHANNELS) : len_raw;
  assign rx_rd_addr = RX_IDX_W'(ADDR_W'(copy_idx_r) + ADDR_W'(HDR_BYTES));

  // channel read: in range and at or below the high-water mark of written channels
  assign chan_m1 = chan_r - CHAN_W'(1);
  assign rd_ok   = (chan_r != '0) && (chan_r <= CHAN_W'(CHANNELS)) &&
                   (chan_r <= CHAN_W'(fill_r));

  assign recent = seen_r && (ms_r < timeout_r);

  // status
  assign st.kind      = kind_r;
  assign st.rx_ge3    = rx_count_r >= RX_CNT_W'(MIN_FRAME);
  assign st.copy_last = (ADDR_W'(copy_idx_r) + ADDR_W'(1)) == ADDR_W'(copy_len_r);
  assign st.out_free  = !out_valid_r || out_ready;

  // item capture and copy bookkeeping
  always_ff @(posedge clk) begin
    if (cmd.latch_item) begin
      kind_r <= in_kind;
      byte_r <= in_data_byte;
      chan_r <= in_channel;
    end
    if (cmd.copy_start) begin
      copy_idx_r <= '0;
      copy_len_r <= CH_CNT_W'(len_clip);
    end else if (cmd.copy_wr) begin
      copy_idx_r <= copy_idx_r + CH_IDX_W'(1);
    end
  end

  // receive store
  always_ff @(posedge clk) begin
    if (cmd.do_byte && (rx_count_r < RX_CNT_W'(RX_DEPTH))) begin
      rx_mem[rx_count_r[RX_IDX_W-1:0]] <= byte_r;
    end
    if (cmd.copy_rd) begin
      rx_rdata_r <= rx_mem[rx_rd_addr];
    end
  end

  // channel store
  always_ff @(posedge clk) begin
    if (cmd.copy_wr) begin
      ch_mem[copy_idx_r] <= rx_rdata_r;
    end
    if (cmd.do_read) begin
      ch_rdata_r <= ch_mem[chan_m1[CH_IDX_W-1:0]];
    end
  end

  // frame state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rx_count_r <= '0;
      pkt_r      <= '0;
      ms_r       <= '0;
      seen_r     <= 1'b0;
      fill_r     <= '0;
      timeout_r  <= TIMEOUT_RST;
      acc_r      <= 1'b0;
      rd_ok_r    <= 1'b0;
    end else begin
      if (cfg_we) begin
        timeout_r <= cfg_data;
      end
      if (cmd.latch_item) begin
        acc_r   <= 1'b0;
        rd_ok_r <= 1'b0;
      end
      if (cmd.do_byte && (rx_count_r < RX_CNT_W'(RX_DEPTH))) begin
        rx_count_r <= rx_count_r + RX_CNT_W'(1);
      end
      if (cmd.do_clear) begin
        rx_count_r <= '0;
      end
      if (cmd.do_tick && (ms_r != '1)) begin
        ms_r <= ms_r + TMO_W'(1);
      end
      if (cmd.do_read) begin
        rd_ok_r <= rd_ok;
      end
      if (cmd.commit) begin
        rx_count_r <= '0;
        pkt_r      <= pkt_r + PKT_W'(1);
        ms_r       <= '0;
        seen_r     <= 1'b1;
        acc_r      <= 1'b1;
        if (copy_len_r > fill_r) begin
          fill_r <= copy_len_r;
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_value_r  <= rd_ok_r ? ch_rdata_r : '0;
      out_pkt_r    <= pkt_r;
      out_recent_r <= recent;
      out_acc_r    <= acc_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_channel_value  = out_value_r;
  assign out_packet_count   = out_pkt_r;
  assign out_data_recent    = out_recent_r;
  assign out_frame_accepted = out_acc_r;

`ifndef SYNTHESIS
  a_copy_in_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.copy_wr |-> (ADDR_W'(copy_idx_r) < ADDR_W'(copy_len_r)))
    else $error("copy index past frame length");

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (ADDR_W'(fill_r) <= ADDR_W'(CHANNELS)) &&
    (ADDR_W'(rx_count_r) <= ADDR_W'(RX_DEPTH)))
    else $error("fill mark or receive count out of range");

  a_commit_restart: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> (ms_r == '0) && seen_r && acc_r && (rx_count_r == '0))
    else $error("commit did not restart frame state");
`endif

endmodule

// ----- src/dfr_ctrl.sv -----
`timescale 1ns / 1ps
module dfr_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  dfr_pkg::status_t  st,
  output dfr_pkg::cmd_t     cmd
);
  import dfr_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE    = 5'b00001,
    S_EXEC    = 5'b00010,
    S_COPY_RD = 5'b00100,
    S_COPY_WR = 5'b01000,
    S_FIN     = 5'b10000
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready = (state_r == S_IDLE);

  // sequencing and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch_item = 1'b1;
          state_nxt      = S_EXEC;
        end
      end
      S_EXEC: begin
        state_nxt = S_FIN;
        unique case (st.kind)
          KIND_BYTE:  cmd.do_byte = 1'b1;
          KIND_BREAK: begin
            if (st.rx_ge3) begin
              cmd.copy_start = 1'b1;
              state_nxt      = S_COPY_RD;
            end else begin
              cmd.do_clear = 1'b1;
            end
          end
          KIND_FLUSH: cmd.do_clear = 1'b1;
          KIND_TICK:  cmd.do_tick  = 1'b1;
          KIND_READ:  cmd.do_read  = 1'b1;
          default: ;
        endcase
      end
      S_COPY_RD: begin
        cmd.copy_rd = 1'b1;
        state_nxt   = S_COPY_WR;
      end
      S_COPY_WR: begin
        cmd.copy_wr = 1'b1;
        if (st.copy_last) begin
          cmd.commit = 1'b1;
          state_nxt  = S_FIN;
        end else begin
          state_nxt = S_COPY_RD;
        end
      end
      S_FIN: begin
        if (st.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

`ifndef SYNTHESIS
  a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> st.out_free)
    else $error("result loaded over an untaken beat");

  a_accept_to_exec: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.latch_item |=> (state_r == S_EXEC))
    else $error("accepted beat not executed");

  a_copy_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_COPY_WR) && st.copy_last |=> (state_r == S_FIN))
    else $error("copy loop did not finish");
`endif

endmodule

// ----- src/dmx512_frame_receiver_unit.sv -----
`timescale 1ns / 1ps
// DMX512 frame receiver working on UART events, one beat per event and one
// result beat per event. Data bytes, overflow flushes, millisecond ticks,
// channel reads and short breaks pass through capture, execute and result
// load, and the block takes no new event before the last one's result is
// loaded. A break that commits a frame of N received bytes copies
// min(N-2, 512) channels: the copy loop moves one channel at a time, a
// read then a write, through the single read port of the receive store
// and the single write port of the channel store. The next input beat is
// taken while a result still waits in the output register.
// No clearing pass runs after reset: channels above the highest one ever
// written read back as zero. The timeout register may be written at any
// time the block is idle; its port is always ready.
module dmx512_frame_receiver_unit (
  input  logic  clk,
  input  logic  rst_n,
  dfr_in_if.sink     in_ch,
  dfr_out_if.source  out_ch,
  dfr_cfg_if.sink    cfg_ch
);
  import dfr_pkg::*;

  cmd_t    cmd;
  status_t st;
  logic    in_ready;

  assign in_ch.ready  = in_ready;
  assign cfg_ch.ready = 1'b1;

  // sequencer
  dfr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  // stores, counters and result register
  dfr_datapath u_datapath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .st                 (st),
    .in_kind            (in_ch.kind),
    .in_data_byte       (in_ch.data_byte),
    .in_channel         (in_ch.channel),
    .cfg_we             (cfg_ch.valid),
    .cfg_data           (cfg_ch.data),
    .out_ready          (out_ch.ready),
    .out_valid          (out_ch.valid),
    .out_channel_value  (out_ch.channel_value),
    .out_packet_count   (out_ch.packet_count),
    .out_data_recent    (out_ch.data_recent),
    .out_frame_accepted (out_ch.frame_accepted)
  );

endmodule

// ----- bench/dmx_frame_checker.sv -----
`timescale 1ns / 1ps
module dmx_frame_checker
  import dfr_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  dfr_in_if    in_ch,
  dfr_out_if   out_ch,
  dfr_cfg_if   cfg_ch,
  output int   fail_count,
  output int   pending
);

  typedef struct packed {
    logic [BYTE_W-1:0] level;
    logic [PKT_W-1:0]  packets;
    logic              recent;
    logic              accepted;
  } dmx_result_t;

  // shadow of the receiver state
  logic [BYTE_W-1:0] rx_store [RX_DEPTH];
  logic [BYTE_W-1:0] level_mem [CHANNELS];
  int                rx_fill;
  logic [PKT_W-1:0]  frames_done;
  logic [TMO_W-1:0]  frame_age;
  logic              got_frame;
  logic [TMO_W-1:0]  recent_window;

  dmx_result_t       expected_q[$];
  int                errs = 0;

  // apply one uart event to the shadow state, return the result it reports
  function dmx_result_t apply_event(input logic [KIND_W-1:0] kind,
                                    input logic [BYTE_W-1:0] b,
                                    input logic [CHAN_W-1:0] ch);
    dmx_result_t r;
    int          n;
    r = '0;
    case (kind)
      KIND_BYTE: begin
        if (rx_fill < RX_DEPTH) begin
          rx_store[rx_fill] = b;
          rx_fill++;
        end
      end
      KIND_BREAK: begin
        // error byte and start code are skipped, the rest land from channel 1
        if (rx_fill >= MIN_FRAME) begin
          n = rx_fill - HDR_BYTES;
          if (n > CHANNELS) n = CHANNELS;
          for (int i = 0; i < n; i++) level_mem[i] = rx_store[i + HDR_BYTES];
          frames_done = frames_done + 1'b1;
          frame_age = '0;
          got_frame = 1'b1;
          r.accepted = 1'b1;
        end
        rx_fill = 0;
      end
      KIND_FLUSH: rx_fill = 0;
      KIND_TICK: begin
        if (frame_age != {TMO_W{1'b1}}) frame_age = frame_age + 1'b1;
      end
      KIND_READ: begin
        if (ch >= 1 && ch <= CHANNELS) r.level = level_mem[ch - 1'b1];
      end
      default: ;
    endcase
    r.packets = frames_done;
    r.recent = got_frame && (frame_age < recent_window);
    return r;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      errs++;
    end
  endtask

  // watch all three channels on every edge
  always @(posedge clk) begin
    dmx_result_t want;
    if (!rst_n) begin
      for (int i = 0; i < CHANNELS; i++) level_mem[i] = '0;
      rx_fill = 0;
      frames_done = '0;
      frame_age = '0;
      got_frame = 1'b0;
      recent_window = TIMEOUT_RST;
      expected_q.delete();
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) recent_window = cfg_ch.data;
      if (in_ch.valid && in_ch.ready)
        expected_q.push_back(apply_event(in_ch.kind, in_ch.data_byte, in_ch.channel));
      if (out_ch.valid && out_ch.ready) begin
        if (expected_q.size() == 0) begin
          $error("unexpected result beat: channel_value %0d packet_count %0d",
                 out_ch.channel_value, out_ch.packet_count);
          errs++;
        end else begin
          want = expected_q.pop_front();
          check_field("channel_value", 32'(want.level), 32'(out_ch.channel_value));
          check_field("packet_count", want.packets, out_ch.packet_count);
          check_field("data_recent", 32'(want.recent), 32'(out_ch.data_recent));
          check_field("frame_accepted", 32'(want.accepted), 32'(out_ch.frame_accepted));
        end
      end
    end
    fail_count <= errs;
    pending <= expected_q.size();
  end

endmodule

// ----- bench/tb_dmx512_frame_receiver_unit.sv -----
`timescale 1ns / 1ps
module tb_dmx512_frame_receiver_unit;
  import dfr_pkg::*;

  logic clk;
  logic rst_n;
  logic idle_en;
  int   hold_seq;
  int   sent;
  int   fail_count;
  int   pending;

  dfr_in_if  in_ch();
  dfr_out_if out_ch();
  dfr_cfg_if cfg_ch();

  dmx512_frame_receiver_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  dmx_frame_checker frame_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_ch     (cfg_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // run limit
  initial begin
    #20_000_000;
    $display("FAIL dmx512_frame_receiver_unit");
    $finish;
  end

  // result side: random stalls plus a long hold-off on request
  initial begin
    int hold_left;
    int hold_seen;
    hold_left = 0;
    hold_seen = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_seq != hold_seen) begin
        hold_seen = hold_seq;
        hold_left = 300;
      end
      if (!rst_n) begin
        out_ch.ready <= 1'b0;
      end else if (hold_left > 0) begin
        out_ch.ready <= 1'b0;
        hold_left--;
      end else begin
        out_ch.ready <= !(idle_en && $urandom_range(99) < 23);
      end
    end
  end

  // one event beat, with random gaps ahead of it
  task automatic post_event(input logic [KIND_W-1:0] kind, input logic [BYTE_W-1:0] b,
                            input logic [CHAN_W-1:0] ch);
    while (idle_en && $urandom_range(99) < 23) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.kind <= kind;
    in_ch.data_byte <= b;
    in_ch.channel <= ch;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sent++;
  endtask

  // n random bytes closed by a break
  task automatic send_frame(input int n);
    for (int i = 0; i < n; i++)
      post_event(KIND_BYTE, BYTE_W'($urandom), CHAN_W'($urandom));
    post_event(KIND_BREAK, BYTE_W'($urandom), CHAN_W'($urandom));
  endtask

  task automatic read_level(input int ch);
    post_event(KIND_READ, BYTE_W'($urandom), CHAN_W'(ch));
  endtask

  task automatic wait_drained(input int settle);
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic write_timeout(input logic [TMO_W-1:0] v);
    wait_drained(8);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data <= v;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  initial begin
    int               base;
    int               n;
    int               pick;
    logic [TMO_W-1:0] tmo;
    idle_en = 1'b1;
    hold_seq = 0;
    sent = 0;
    rst_n = 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.kind <= KIND_BYTE;
    in_ch.data_byte <= '0;
    in_ch.channel <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.data <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty and short frames, a five-byte frame, reads at the edges
    read_level(1);
    post_event(KIND_BREAK, 8'hFF, 10'h3FF);
    post_event(KIND_BYTE, 8'h00, 10'h000);
    post_event(KIND_BYTE, 8'hFF, 10'h3FF);
    post_event(KIND_BREAK, 8'h00, 10'h000);
    post_event(KIND_BYTE, 8'h55, 10'h155);
    post_event(KIND_BYTE, 8'hAA, 10'h2AA);
    post_event(KIND_BYTE, 8'hFF, 10'h000);
    post_event(KIND_BYTE, 8'h80, 10'h000);
    post_event(KIND_BYTE, 8'h01, 10'h000);
    post_event(KIND_BREAK, 8'h00, 10'h000);
    read_level(0);
    read_level(1);
    read_level(3);
    read_level(4);
    read_level(CHANNELS);
    read_level(CHANNELS + 1);
    read_level(1023);
    // flushed partial frame leaves nothing to commit
    post_event(KIND_BYTE, 8'h7F, 10'h000);
    post_event(KIND_FLUSH, 8'h00, 10'h000);
    post_event(KIND_BREAK, 8'h00, 10'h000);
    post_event(KIND_TICK, 8'h00, 10'h000);
    for (int k = KIND_READ + 1; k < (1 << KIND_W); k++)
      post_event(KIND_W'(k), 8'hA5, 10'h2AA);

    // zero window: never recent
    write_timeout('0);
    send_frame(5);
    read_level(2);
    post_event(KIND_TICK, 8'h00, 10'h000);

    // one-tick window
    write_timeout(TMO_W'(1));
    send_frame(4);
    read_level(1);
    post_event(KIND_TICK, 8'h00, 10'h000);
    read_level(2);

    // result side held off while events keep coming
    hold_seq++;
    for (int i = 0; i < 12; i++) read_level($urandom_range(8, 1));

    // overfull store without idling: bytes past the depth are dropped
    write_timeout(TIMEOUT_RST);
    idle_en = 1'b0;
    send_frame(RX_DEPTH + 1);
    idle_en = 1'b1;
    for (int i = 0; i < 6; i++) read_level($urandom_range(CHANNELS + 2, CHANNELS - 8));

    // random blocks, a fresh window before each
    for (int blk = 0; blk < 2; blk++) begin
      case ($urandom_range(9))
        0: tmo = '0;
        1: tmo = TMO_W'(1);
        2: tmo = {TMO_W{1'b1}};
        3: tmo = TMO_W'($urandom);
        default: tmo = TMO_W'($urandom_range(30, 1));
      endcase
      write_timeout(tmo);
      base = sent;
      while (sent < base + 20) begin
        if (blk == 1 && sent >= base + 10 && sent < base + 15) wait_drained(0);
        pick = $urandom_range(99);
        if (pick < 50) begin
          // mostly well-formed frames, sometimes cut off by an overflow flush
          if ($urandom_range(99) < 10) begin
            n = $urandom_range(6, 1);
            for (int i = 0; i < n; i++)
              post_event(KIND_BYTE, BYTE_W'($urandom), CHAN_W'($urandom));
            post_event(KIND_FLUSH, BYTE_W'($urandom), CHAN_W'($urandom));
          end
          n = ($urandom_range(99) < 85) ? $urandom_range(24, MIN_FRAME)
                                        : $urandom_range(MIN_FRAME - 1, 0);
          send_frame(n);
        end else if (pick < 70) begin
          n = $urandom_range(4, 1);
          for (int i = 0; i < n; i++)
            read_level(($urandom_range(99) < 80) ? $urandom_range(48, 1)
                                                 : $urandom_range(1023));
        end else if (pick < 88) begin
          n = $urandom_range(6, 1);
          for (int i = 0; i < n; i++)
            post_event(KIND_TICK, BYTE_W'($urandom), CHAN_W'($urandom));
        end else begin
          post_event(KIND_W'($urandom_range(7)), BYTE_W'($urandom), CHAN_W'($urandom));
        end
      end
    end

    // widest window, a few ticks after a minimal frame
    write_timeout({TMO_W{1'b1}});
    send_frame(MIN_FRAME);
    for (int i = 0; i < 3; i++) post_event(KIND_TICK, '0, '0);
    read_level(1);

    // longest break copy bounds the settle time
    wait_drained(1100);
    if (fail_count == 0 && pending == 0) begin
      $display("PASS dmx512_frame_receiver_unit");
    end else begin
      $display("FAIL dmx512_frame_receiver_unit");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
src/dfr_pkg.sv
src/dfr_if.sv
src/dfr_datapath.sv
src/dfr_ctrl.sv
src/dmx512_frame_receiver_unit.sv
bench/dmx_frame_checker.sv
bench/tb_dmx512_frame_receiver_unit.sv
